>>> src/bpf_pkg.sv
package bpf_pkg;

    // default build values
    localparam int DEPTH_DEF        = 4096;
    localparam int ATOMIC_LIMIT_DEF = 4096;
    localparam int MAX_HANDLES_DEF  = 255;

    // read and write end counts saturate here
    localparam int END_LIMIT = 255;

    // field widths
    localparam int LEN_W   = 16;
    localparam int LVL_W   = 13;
    localparam int CNT_W   = 8;
    // wide enough for any depth, request length or atomic limit
    localparam int CALC_W  = 17;

    typedef enum logic [2:0] {
        MODE_ADD_REF     = 3'd0,
        MODE_OPEN_READ   = 3'd1,
        MODE_OPEN_WRITE  = 3'd2,
        MODE_CLOSE_READ  = 3'd3,
        MODE_CLOSE_WRITE = 3'd4,
        MODE_PUSH        = 3'd5,
        MODE_POP         = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EOF         = 3'd1,
        ST_WOULD_BLOCK = 3'd2,
        ST_BROKEN_PIPE = 3'd3,
        ST_DROPPED     = 3'd4
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic [7:0]         data_byte;
        logic               first_of_write;
        logic [LEN_W-1:0]   request_length;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic [7:0]         read_data;
        logic [LVL_W-1:0]   admitted_length;
        logic [CNT_W-1:0]   reader_count;
        logic [CNT_W-1:0]   writer_count;
        logic [LVL_W-1:0]   fill_level;
        logic               released;
    } t_out;

endpackage

>>> src/bpf_ring_mem.sv
module bpf_ring_mem #(
    parameter int DEPTH = bpf_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0]  r_mem [DEPTH];
    logic [7:0]  r_mem_q;
    logic        r_byp;
    logic [7:0]  r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_mem_q    <= r_mem[i_raddr];
        // write to the address being read lands in the same cycle
        r_byp      <= i_we && (i_waddr == i_raddr);
        r_byp_data <= i_wdata;
    end

    assign o_rdata = r_byp ? r_byp_data : r_mem_q;

endmodule

>>> src/bpf_core.sv
module bpf_core #(
    parameter int DEPTH        = bpf_pkg::DEPTH_DEF,
    parameter int ATOMIC_LIMIT = bpf_pkg::ATOMIC_LIMIT_DEF,
    parameter int MAX_HANDLES  = bpf_pkg::MAX_HANDLES_DEF,
    parameter int AW           = $clog2(DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  bpf_pkg::t_in   i_item,
    input  logic           i_named_pipe_we,
    input  logic           i_named_pipe_wdata,
    input  logic [7:0]     i_head_data,
    output bpf_pkg::t_out  o_result,
    output logic           o_we,
    output logic [AW-1:0]  o_waddr,
    output logic [7:0]     o_wdata,
    output logic [AW-1:0]  o_raddr
);

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int HW    = $clog2(MAX_HANDLES + 1);
    localparam int CW    = bpf_pkg::CALC_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0]              r_head, n_head;
    logic [AW-1:0]              r_tail, n_tail;
    logic [OCC_W-1:0]           r_occ, n_occ;
    logic [OCC_W-1:0]           r_budget, n_budget;
    logic [bpf_pkg::CNT_W-1:0]  r_readers, n_readers;
    logic [bpf_pkg::CNT_W-1:0]  r_writers, n_writers;
    logic [HW-1:0]              r_refs, n_refs;
    logic                       r_named;

    logic [CW-1:0]              space;
    logic [CW-1:0]              len_ext;
    logic [CW-1:0]              admitted;
    logic [CW-1:0]              occ_wide;
    logic                       store;
    logic                       released;
    bpf_pkg::t_status           status;
    logic [7:0]                 rdata;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_occ     = r_occ;
        n_budget  = r_budget;
        n_readers = r_readers;
        n_writers = r_writers;
        n_refs    = r_refs;
        status    = bpf_pkg::ST_OK;
        rdata     = '0;
        admitted  = '0;
        released  = 1'b0;
        store     = 1'b0;
        space     = CW'(DEPTH) - CW'(r_occ);
        len_ext   = CW'(i_item.request_length);

        unique case (i_item.mode)
            bpf_pkg::MODE_ADD_REF: begin
                if (r_refs < HW'(MAX_HANDLES)) n_refs = r_refs + 1'b1;
            end
            bpf_pkg::MODE_OPEN_READ: begin
                if (r_refs < HW'(MAX_HANDLES)) n_refs = r_refs + 1'b1;
                if (r_readers < bpf_pkg::CNT_W'(bpf_pkg::END_LIMIT))
                    n_readers = r_readers + 1'b1;
            end
            bpf_pkg::MODE_OPEN_WRITE: begin
                if (r_refs < HW'(MAX_HANDLES)) n_refs = r_refs + 1'b1;
                if (r_writers < bpf_pkg::CNT_W'(bpf_pkg::END_LIMIT))
                    n_writers = r_writers + 1'b1;
            end
            bpf_pkg::MODE_CLOSE_READ, bpf_pkg::MODE_CLOSE_WRITE: begin
                if (i_item.mode == bpf_pkg::MODE_CLOSE_READ) begin
                    if (r_readers != '0) n_readers = r_readers - 1'b1;
                end else begin
                    if (r_writers != '0) n_writers = r_writers - 1'b1;
                end
                if (r_refs != '0) begin
                    n_refs   = r_refs - 1'b1;
                    released = (r_refs == HW'(1)) && !r_named;
                end
            end
            bpf_pkg::MODE_PUSH: begin
                if (i_item.first_of_write) begin
                    n_budget = '0;
                    if (r_readers == '0) begin
                        status = bpf_pkg::ST_BROKEN_PIPE;
                    end else if (space == '0) begin
                        status = bpf_pkg::ST_WOULD_BLOCK;
                    end else if (len_ext <= CW'(ATOMIC_LIMIT) && space < len_ext) begin
                        status = bpf_pkg::ST_WOULD_BLOCK;
                    end else begin
                        admitted = (len_ext < space) ? len_ext : space;
                        if (admitted != '0) begin
                            store    = 1'b1;
                            n_budget = admitted[OCC_W-1:0] - 1'b1;
                        end
                    end
                end else if (r_budget != '0 && r_occ < OCC_W'(DEPTH)) begin
                    store    = 1'b1;
                    n_budget = r_budget - 1'b1;
                end else begin
                    status = bpf_pkg::ST_DROPPED;
                end
                if (store) begin
                    n_tail = wrap_inc(r_tail);
                    n_occ  = r_occ + 1'b1;
                end
            end
            bpf_pkg::MODE_POP: begin
                if (r_occ == '0) begin
                    status = (r_writers == '0) ? bpf_pkg::ST_EOF : bpf_pkg::ST_WOULD_BLOCK;
                end else begin
                    rdata  = i_head_data;
                    n_head = wrap_inc(r_head);
                    n_occ  = r_occ - 1'b1;
                end
            end
            default: begin
                // unused mode: no change, ok
            end
        endcase
    end

    assign occ_wide = CW'(n_occ);

    always_comb begin
        o_result.status          = status;
        o_result.read_data       = rdata;
        o_result.admitted_length = admitted[bpf_pkg::LVL_W-1:0];
        o_result.reader_count    = n_readers;
        o_result.writer_count    = n_writers;
        o_result.fill_level      = occ_wide[bpf_pkg::LVL_W-1:0];
        o_result.released        = released;
    end

    assign o_we    = i_fire && store;
    assign o_waddr = r_tail;
    assign o_wdata = i_item.data_byte;
    // read ahead at the head that the next transaction will see
    assign o_raddr = i_fire ? n_head : r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_occ     <= '0;
            r_budget  <= '0;
            r_readers <= '0;
            r_writers <= '0;
            r_refs    <= '0;
            r_named   <= 1'b0;
        end else begin
            if (i_fire) begin
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_occ     <= n_occ;
                r_budget  <= n_budget;
                r_readers <= n_readers;
                r_writers <= n_writers;
                r_refs    <= n_refs;
            end
            if (i_named_pipe_we) r_named <= i_named_pipe_wdata;
        end
    end

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(DEPTH))
        else $error("fill level above depth");

    a_budget_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (18'(r_budget) + 18'(r_occ)) <= 18'(DEPTH))
        else $error("write budget exceeds free space");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.mode == bpf_pkg::MODE_POP && r_occ != '0)
            |=> (r_occ == $past(r_occ) - 1'b1))
        else $error("successful pop did not drain one byte");
`endif

endmodule

>>> src/byte_pipe_fifo_with_endpoint_counts.sv
// pipeline: input register, then result register, for each accepted transaction
// throughput: 1 transaction per cycle unless stalled, set by the single state-update
//   stage and the one-write/one-read ring memory with read-ahead at the head
// reset: i_rst_n synchronous, active low; clears pointers, counts, budget,
//   the named_pipe register and both pipeline valids; ring memory is not cleared
module byte_pipe_fifo_with_endpoint_counts #(
    parameter int DEPTH        = bpf_pkg::DEPTH_DEF,
    parameter int ATOMIC_LIMIT = bpf_pkg::ATOMIC_LIMIT_DEF,
    parameter int MAX_HANDLES  = bpf_pkg::MAX_HANDLES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // input transactions
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bpf_pkg::t_in   i_in,
    // result transactions
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output bpf_pkg::t_out  o_out,
    // named_pipe register
    input  logic           i_named_pipe_we,
    input  logic           i_named_pipe_wdata
);

    localparam int AW = $clog2(DEPTH);

    // input register
    logic           r_in_valid;
    bpf_pkg::t_in   r_in;
    // result register
    logic           r_out_valid;
    bpf_pkg::t_out  r_out;

    logic           fire;
    logic           accept;
    bpf_pkg::t_out  result;

    // memory hookup
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic [AW-1:0]  mem_raddr;
    logic [7:0]     head_data;

    // the held transaction is processed once the result register is free
    // or is being emptied this cycle
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign accept     = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    bpf_core #(
        .DEPTH        (DEPTH),
        .ATOMIC_LIMIT (ATOMIC_LIMIT),
        .MAX_HANDLES  (MAX_HANDLES),
        .AW           (AW)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (fire),
        .i_item             (r_in),
        .i_named_pipe_we    (i_named_pipe_we),
        .i_named_pipe_wdata (i_named_pipe_wdata),
        .i_head_data        (head_data),
        .o_result           (result),
        .o_we               (mem_we),
        .o_waddr            (mem_waddr),
        .o_wdata            (mem_wdata),
        .o_raddr            (mem_raddr)
    );

    // ring storage, read data always reflects the current head
    bpf_ring_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (head_data)
    );

    // valids are control state, payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_in <= i_in;
        if (fire) r_out <= result;
    end

endmodule
